[rtl/button_click_press_detector_top_defines.svh]
// Assertion macros for the button click / press detector.
// Used by bcpd_core and button_click_press_detector_top; they expect clk and arst_n in scope.
`ifndef BUTTON_CLICK_PRESS_DETECTOR_TOP_DEFINES_SVH
`define BUTTON_CLICK_PRESS_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every clock edge outside reset.
`define BCPD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcpd assertion failed");

// Next-cycle implication.
`define BCPD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcpd assertion failed");

`else

`define BCPD_ASSERT_IMP(label, ante, cons)
`define BCPD_ASSERT_NXT(label, ante, cons)

`endif

`endif

[rtl/bcpd_pkg.sv]
// Shared types and register indexes for the button click / press detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcpd_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 2'd0,
		CFG_LONG_PRESS = 2'd1,
		CFG_CLICK_GAP  = 2'd2,
		CFG_MAX_CLICKS = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [15:0] LONG_PRESS_RST = 16'd800;
	localparam logic [15:0] CLICK_GAP_RST  = 16'd400;
	localparam logic [3:0]  MAX_CLICKS_RST = 4'd3;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
		logic [15:0] click_gap_ms;
		logic [3:0]  max_clicks;
	} cfg_t;

	typedef struct packed {
		logic        level_active;
		logic [31:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic       was_idle;
		logic       press_start;
		logic       press_held;
		logic       press_end;
		logic [3:0] clicks_done;
	} result_t;

endpackage

`default_nettype wire

[rtl/bcpd_cfg.sv]
// Configuration registers of the button click / press detector.
// Depends on bcpd_pkg.
`default_nettype none

module bcpd_cfg
	import bcpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
			cfg_q.click_gap_ms  <= CLICK_GAP_RST;
			cfg_q.max_clicks    <= MAX_CLICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data;
				CFG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data;
				CFG_CLICK_GAP:  cfg_q.click_gap_ms  <= cfg_data;
				CFG_MAX_CLICKS: cfg_q.max_clicks    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/bcpd_core.sv]
// Mode machine of the detector: state registers and one-item step logic.
// Depends on bcpd_pkg and the assertion macro header.
`default_nettype none

`include "button_click_press_detector_top_defines.svh"

module bcpd_core
	import bcpd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    fire,
	input  wire sample_t item,
	input  wire cfg_t    cfg,
	output result_t      result
);

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_DOWN     = 3'd1,
		MODE_UP       = 3'd2,
		MODE_COUNT    = 3'd3,
		MODE_PRESS    = 3'd4,
		MODE_PRESSEND = 3'd5
	} mode_t;

	mode_t       mode_q, prev_q, mode_d, prev_d;
	logic [31:0] mark_q, mark_d;
	logic [3:0]  tally_q, tally_d;
	logic [31:0] elapsed;
	logic        db_short, db_done, long_hit, gap_hit;
	result_t     res;

	// Elapsed time wraps modulo 2^32.
	assign elapsed  = item.time_ms - mark_q;
	assign db_short = elapsed <  {16'd0, cfg.debounce_ms};
	assign db_done  = !db_short;
	assign long_hit = elapsed >  {16'd0, cfg.long_press_ms};
	assign gap_hit  = elapsed >  {16'd0, cfg.click_gap_ms};

	always_comb begin
		mode_d  = mode_q;
		prev_d  = prev_q;
		mark_d  = mark_q;
		tally_d = tally_q;
		res     = '0;
		res.was_idle = (mode_q == MODE_IDLE);
		case (mode_q)
			MODE_IDLE: begin
				if (item.level_active) begin
					prev_d  = mode_q;
					mode_d  = MODE_DOWN;
					mark_d  = item.time_ms;
					tally_d = '0;
				end
			end
			MODE_DOWN: begin
				if (!item.level_active && db_short) begin
					// bounce: swap back
					prev_d = mode_q;
					mode_d = prev_q;
				end else if (!item.level_active) begin
					prev_d = mode_q;
					mode_d = MODE_UP;
					mark_d = item.time_ms;
				end else if (long_hit) begin
					res.press_start = 1'b1;
					prev_d = mode_q;
					mode_d = MODE_PRESS;
				end
			end
			MODE_UP: begin
				if (item.level_active && db_short) begin
					prev_d = mode_q;
					mode_d = prev_q;
				end else if (db_done) begin
					tally_d = tally_q + 4'd1;
					prev_d  = mode_q;
					mode_d  = MODE_COUNT;
				end
			end
			MODE_COUNT: begin
				if (item.level_active) begin
					prev_d = mode_q;
					mode_d = MODE_DOWN;
					mark_d = item.time_ms;
				end else if (gap_hit || tally_q == cfg.max_clicks) begin
					res.clicks_done = tally_q;
					mode_d  = MODE_IDLE;
					prev_d  = MODE_IDLE;
					mark_d  = '0;
					tally_d = '0;
				end
			end
			MODE_PRESS: begin
				if (!item.level_active) begin
					prev_d = mode_q;
					mode_d = MODE_PRESSEND;
					mark_d = item.time_ms;
				end else begin
					res.press_held = 1'b1;
				end
			end
			MODE_PRESSEND: begin
				if (item.level_active && db_short) begin
					prev_d = mode_q;
					mode_d = prev_q;
				end else if (db_done) begin
					res.press_end = 1'b1;
					mode_d  = MODE_IDLE;
					prev_d  = MODE_IDLE;
					mark_d  = '0;
					tally_d = '0;
				end
			end
			default: begin
				// unused codes: fall back to idle, keep tally and mark
				mode_d = MODE_IDLE;
				prev_d = MODE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			prev_q  <= MODE_IDLE;
			mark_q  <= '0;
			tally_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			prev_q  <= prev_d;
			mark_q  <= mark_d;
			tally_q <= tally_d;
		end
	end

	assign result = res;

	`BCPD_ASSERT_IMP(a_idle_no_tally, mode_q == MODE_IDLE, tally_q == 4'd0)
	`BCPD_ASSERT_NXT(a_start_enters_press, fire && res.press_start, mode_q == MODE_PRESS)
	`BCPD_ASSERT_NXT(a_done_rests, fire && res.clicks_done != 4'd0,
		mode_q == MODE_IDLE && prev_q == MODE_IDLE && mark_q == 32'd0)

endmodule

`default_nettype wire

[rtl/button_click_press_detector_top.sv]
// Top level of the button click / press detector: input register, result register.
// Depends on bcpd_pkg, bcpd_cfg, bcpd_core and the assertion macro header.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  sample   | sample_valid / stall    | sample_t: level_active, time_ms
//  result   | result_valid / stall    | result_t: was_idle, press_*, clicks_done
//  cfg      | cfg_we (no wait)        | cfg_index, cfg_data (16 bit)
//
// One item per cycle while the result is not stalled; an accepted sample passes through
// the input register and then the result register before its result can leave.
// The mode machine step (32-bit subtract, compares, mode update) sits between
// the input register and the result register; its state is registered and feeds back.
// Reset puts the machine in idle with a clear mark and tally, and loads the
// register defaults (debounce 50, long press 800, click gap 400, max clicks 3).
// A stalled result holds in its register while one more item waits in the
// input register; sample_stall rises only when both are full.
`default_nettype none

`include "button_click_press_detector_top_defines.svh"

module button_click_press_detector_top
	import bcpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  sample_valid,
	output logic                       sample_stall,
	input  wire sample_t               sample,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result
);

	cfg_t    cfg;
	sample_t item_s1;
	logic    valid_s1;
	result_t step_res;
	result_t result_q;
	logic    result_valid_q;
	logic    advance;
	logic    load_s1;

	// Move the held item into the result register whenever that slot frees up.
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign load_s1      = sample_valid && !sample_stall;

	bcpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The machine steps exactly when its item leaves the input register.
	bcpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (step_res)
	);

	// Control: occupancy of both registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1       <= load_s1 || (valid_s1 && !advance);
			result_valid_q <= advance || (result_valid_q && result_stall);
		end
	end

	// Payload: load on acceptance, hold otherwise.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= sample;
		end
		if (advance) begin
			result_q <= step_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`BCPD_ASSERT_IMP(a_one_event, result_valid_q,
		$onehot0({result_q.press_start, result_q.press_held, result_q.press_end,
			result_q.clicks_done != 4'd0}))
	`BCPD_ASSERT_IMP(a_idle_quiet, result_valid_q && result_q.was_idle,
		!result_q.press_start && !result_q.press_held && !result_q.press_end)
	`BCPD_ASSERT_IMP(a_empty_never_stalls, !valid_s1, !sample_stall)

endmodule

`default_nettype wire
